FILE: design/rkuds_pkg.sv
// ----------------------------------------------------------------------------
// rkuds_pkg
// Shared types and constants for the row k-nearest-neighbor selector.
// ----------------------------------------------------------------------------
package rkuds_pkg;

  localparam int unsigned ROW_MAX_DEF  = 64;
  localparam int unsigned ROW_MAX_LIM  = 1024;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned IDX_W        = 24;
  localparam int unsigned DIST_W       = 32;
  localparam int unsigned LIMIT_W      = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CNT_MAX_W    = $clog2(ROW_MAX_LIM + 1);
  localparam int unsigned ADDR_MAX_W   = $clog2(ROW_MAX_LIM);

  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DISTINCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_TOLERANCE  = 2'd2;

  typedef struct packed {
    logic [CNT_MAX_W-1:0] count;
    logic [IDX_W-1:0]     row;
    logic                 overflow;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [IDX_W-1:0]      column;
    logic [DIST_W-1:0]     distance;
  } wr_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] neighbor_limit;
    logic               count_distinct;
    logic [DIST_W-1:0]  tie_tolerance;
  } cfg_t;

endpackage

FILE: design/rkuds_front.sv
// ----------------------------------------------------------------------------
// rkuds_front
// Accepts row entries, writes them to the row buffer, issues a job per row.
// ----------------------------------------------------------------------------
module rkuds_front #(
  parameter int unsigned ROW_MAX = rkuds_pkg::ROW_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [rkuds_pkg::IDX_W-1:0] row_index_i,
  input  logic [rkuds_pkg::IDX_W-1:0] column_index_i,
  input  logic [rkuds_pkg::DIST_W-1:0] distance_i,
  input  logic                        row_end_i,
  output rkuds_pkg::wr_t              wr_o,
  output logic                        push_o,
  output rkuds_pkg::job_t             job_o
);
  import rkuds_pkg::*;

  localparam int unsigned CW = $clog2(ROW_MAX + 1);
  localparam logic [CW-1:0] FULL = CW'(ROW_MAX);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] row_sel;
  logic             room;

  assign room    = (cnt_q < FULL);
  assign row_sel = (cnt_q == '0 && !ovf_q) ? row_index_i : row_q;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    row_d = row_q;
    wr_o  = '0;
    push_o = 1'b0;
    job_o = '0;
    if (accept_i) begin
      row_d = row_sel;
      if (room) begin
        wr_o.en       = 1'b1;
        wr_o.addr     = ADDR_MAX_W'(cnt_q);
        wr_o.column   = column_index_i;
        wr_o.distance = distance_i;
        cnt_d         = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if (row_end_i) begin
        push_o         = 1'b1;
        job_o.count    = CNT_MAX_W'(cnt_d);
        job_o.row      = row_sel;
        job_o.overflow = ovf_d;
        cnt_d          = '0;
        ovf_d          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      row_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: design/rkuds_jobq.sv
// ----------------------------------------------------------------------------
// rkuds_jobq
// Single-entry job queue between the front and the selection engine.
// ----------------------------------------------------------------------------
module rkuds_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rkuds_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            valid_o,
  output rkuds_pkg::job_t job_o
);
  import rkuds_pkg::*;

  logic valid_q;
  job_t job_q;

  assign valid_o = valid_q;
  assign job_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q <= job_i;
    end
  end

endmodule

FILE: design/rkuds_back.sv
// ----------------------------------------------------------------------------
// rkuds_back
// Row buffer and selection engine: repeated minimum scans in stable order.
// ----------------------------------------------------------------------------
module rkuds_back #(
  parameter int unsigned ROW_MAX = rkuds_pkg::ROW_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rkuds_pkg::wr_t               wr_i,
  input  logic                         job_valid_i,
  input  rkuds_pkg::job_t              job_i,
  input  rkuds_pkg::cfg_t              cfg_i,
  output logic                         pop_o,
  output logic                         active_o,
  output logic                         out_valid_o,
  output logic [rkuds_pkg::IDX_W-1:0]  out_row_o,
  output logic [rkuds_pkg::IDX_W-1:0]  out_column_o,
  output logic [rkuds_pkg::DIST_W-1:0] out_distance_o,
  output logic                         out_last_o,
  output logic                         row_overflow_o
);
  import rkuds_pkg::*;

  localparam int unsigned CW = $clog2(ROW_MAX + 1);
  localparam int unsigned AW = $clog2(ROW_MAX);
  localparam int unsigned EW = $clog2(MAX_RESULTS + 1);
  localparam logic [EW-1:0] EMIT_CAP = EW'(MAX_RESULTS);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_FLUSH, S_DONE} state_e;

  logic [IDX_W+DIST_W-1:0] mem [ROW_MAX];
  logic [IDX_W+DIST_W-1:0] rd_q;

  state_e             state_q;
  logic [CW-1:0]      a_q;
  logic               v_q;
  logic [AW-1:0]      i_q;
  logic               found_q, have_last_q, have_prev_q, pend_q;
  logic [DIST_W-1:0]  best_d_q, last_d_q, prev_q;
  logic [IDX_W-1:0]   best_c_q;
  logic [AW-1:0]      best_i_q, last_i_q;
  logic [LIMIT_W-1:0] kept_q, uniq_q;
  logic [EW-1:0]      emit_q;
  logic [IDX_W-1:0]   pc_q;
  logic [DIST_W-1:0]  pd_q;

  logic [IDX_W-1:0]   rd_c;
  logic [DIST_W-1:0]  rd_d, diff;
  logic [CW-1:0]      n;
  logic               elig, better, issue;
  logic [LIMIT_W-1:0] count_now;

  assign rd_c   = rd_q[IDX_W+DIST_W-1:DIST_W];
  assign rd_d   = rd_q[DIST_W-1:0];
  assign n      = job_i.count[CW-1:0];
  assign issue  = (state_q == S_SCAN) && (a_q < n);
  assign elig   = !have_last_q || (rd_d > last_d_q) ||
                  ((rd_d == last_d_q) && (i_q > last_i_q));
  assign better = !found_q || (rd_d < best_d_q);
  assign diff   = (best_d_q >= prev_q) ? best_d_q - prev_q : prev_q - best_d_q;
  assign count_now = cfg_i.count_distinct ? uniq_q : kept_q;
  assign active_o  = (state_q != S_IDLE);
  assign pop_o     = (state_q == S_DONE);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= {wr_i.column, wr_i.distance};
    end
    if (issue) begin
      rd_q <= mem[a_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= '0;
      v_q         <= 1'b0;
      i_q         <= '0;
      found_q     <= 1'b0;
      have_last_q <= 1'b0;
      have_prev_q <= 1'b0;
      pend_q      <= 1'b0;
      best_d_q    <= '0;
      best_c_q    <= '0;
      best_i_q    <= '0;
      last_d_q    <= '0;
      last_i_q    <= '0;
      prev_q      <= '0;
      kept_q      <= '0;
      uniq_q      <= '0;
      emit_q      <= '0;
      pc_q        <= '0;
      pd_q        <= '0;
      out_valid_o <= 1'b0;
      out_last_o  <= 1'b0;
      out_row_o      <= '0;
      out_column_o   <= '0;
      out_distance_o <= '0;
      row_overflow_o <= 1'b0;
    end else begin
      out_valid_o <= 1'b0;
      out_last_o  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            have_last_q <= 1'b0;
            have_prev_q <= 1'b0;
            pend_q      <= 1'b0;
            found_q     <= 1'b0;
            kept_q      <= '0;
            uniq_q      <= '0;
            emit_q      <= '0;
            a_q         <= '0;
            v_q         <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          v_q <= issue;
          i_q <= a_q[AW-1:0];
          if (issue) begin
            a_q <= a_q + 1'b1;
          end
          if (v_q && elig && better) begin
            found_q  <= 1'b1;
            best_d_q <= rd_d;
            best_c_q <= rd_c;
            best_i_q <= i_q;
          end
          if (!issue && !v_q) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          a_q     <= '0;
          found_q <= 1'b0;
          state_q <= S_SCAN;
          if (!found_q) begin
            state_q <= S_FLUSH;
          end else begin
            have_last_q <= 1'b1;
            last_d_q    <= best_d_q;
            last_i_q    <= best_i_q;
            if (best_c_q != job_i.row) begin
              if (count_now >= cfg_i.neighbor_limit) begin
                state_q <= S_FLUSH;
              end else begin
                if (pend_q) begin
                  out_valid_o    <= 1'b1;
                  out_row_o      <= job_i.row;
                  out_column_o   <= pc_q;
                  out_distance_o <= pd_q;
                  row_overflow_o <= job_i.overflow;
                end
                pend_q <= 1'b1;
                pc_q   <= best_c_q;
                pd_q   <= best_d_q;
                kept_q <= kept_q + 1'b1;
                emit_q <= emit_q + 1'b1;
                if (!have_prev_q || diff >= cfg_i.tie_tolerance) begin
                  uniq_q      <= uniq_q + 1'b1;
                  prev_q      <= best_d_q;
                  have_prev_q <= 1'b1;
                end
                if (emit_q + 1'b1 == EMIT_CAP) begin
                  state_q <= S_FLUSH;
                end
              end
            end
          end
        end
        S_FLUSH: begin
          if (pend_q) begin
            out_valid_o    <= 1'b1;
            out_last_o     <= 1'b1;
            out_row_o      <= job_i.row;
            out_column_o   <= pc_q;
            out_distance_o <= pd_q;
            row_overflow_o <= job_i.overflow;
          end
          pend_q  <= 1'b0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/row_knn_unique_distance_select_top.sv
// ----------------------------------------------------------------------------
// row_knn_unique_distance_select_top
// Per-row k-nearest-neighbor selection with optional distinct-distance count.
//
//   channel   handshake                 payload
//   entry     start / busy              row_index_i column_index_i distance_i row_end_i
//   config    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//   result    out_valid_o (strobe)      out_row_o out_column_o out_distance_o
//                                       out_last_o row_overflow_o
//
// Non-final entries are accepted while busy is low. A row end starts the
// selection engine; busy stays high until it finishes. Each selection pass
// scans the buffered row once through the buffer read port, with one pass
// per entry visited in order (self entries included) plus one closing pass
// when the row runs out; the engine also starts, flushes and releases.
// Reset clears all control state; the row buffer needs no clearing.
// Results are single-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module row_knn_unique_distance_select_top #(
  parameter int unsigned ROW_MAX = rkuds_pkg::ROW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rkuds_pkg::IDX_W-1:0]       row_index_i,
  input  logic [rkuds_pkg::IDX_W-1:0]       column_index_i,
  input  logic [rkuds_pkg::DIST_W-1:0]      distance_i,
  input  logic                              row_end_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rkuds_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rkuds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                              out_valid_o,
  output logic [rkuds_pkg::IDX_W-1:0]       out_row_o,
  output logic [rkuds_pkg::IDX_W-1:0]       out_column_o,
  output logic [rkuds_pkg::DIST_W-1:0]      out_distance_o,
  output logic                              out_last_o,
  output logic                              row_overflow_o
);
  import rkuds_pkg::*;

  cfg_t cfg_q;
  wr_t  wr;
  job_t job_in, job_out;
  logic push, pop, q_valid, active, accept;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_valid || active;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neighbor_limit <= LIMIT_W'(10);
      cfg_q.count_distinct <= 1'b0;
      cfg_q.tie_tolerance  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NEIGHBOR_LIMIT: cfg_q.neighbor_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_COUNT_DISTINCT: cfg_q.count_distinct <= cfg_data_i[0];
        CFG_TIE_TOLERANCE:  cfg_q.tie_tolerance  <= cfg_data_i[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rkuds_front #(.ROW_MAX(ROW_MAX)) u_front (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .row_index_i, .column_index_i, .distance_i, .row_end_i,
    .wr_o(wr), .push_o(push), .job_o(job_in)
  );

  rkuds_jobq u_jobq (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(job_in), .pop_i(pop),
    .valid_o(q_valid), .job_o(job_out)
  );

  rkuds_back #(.ROW_MAX(ROW_MAX)) u_back (
    .clk_i, .rst_ni,
    .wr_i(wr), .job_valid_i(q_valid), .job_i(job_out), .cfg_i(cfg_q),
    .pop_o(pop), .active_o(active),
    .out_valid_o, .out_row_o, .out_column_o, .out_distance_o,
    .out_last_o, .row_overflow_o
  );

  a_out_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result outside a row job");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |=> !out_valid_o) else $error("result after last");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> !wr.en) else $error("buffer written during selection");

endmodule
